### hw/rtl/pse_pkg.sv
// Shared types and codes for the permutation step engine.
// No dependencies; imported by pse_core, the top level, pse_checker and tb.
package pse_pkg;

  // Fixed field widths of the request and result items
  localparam int CMD_W      = 2;
  localparam int POS_W      = 4;
  localparam int VAL_W      = 16;
  localparam int SEQ_LEN_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 2'd1;

  // Reset values of the configuration registers
  localparam logic [SEQ_LEN_W-1:0] SEQ_LENGTH_RST = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             advanced;
  } res_t;

  typedef struct packed {
    logic                 direction;
    logic [SEQ_LEN_W-1:0] seq_length;
  } cfg_t;

endpackage

### hw/rtl/pse_cmp.sv
// Shared ordering compare unit of the permutation step engine.
// Depends on nothing but its inputs; used by pse_core for every element compare.
module pse_cmp #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         prev,
  output logic         ahead
);

  // a comes ahead of b: ascending order for next, descending for previous
  always_comb begin
    if (prev) begin
      ahead = (a > b);
    end else begin
      ahead = (a < b);
    end
  end

endmodule

### hw/rtl/pse_core.sv
// Sequencer, element memory and result register of the permutation engine.
// Depends on pse_pkg and the shared compare unit pse_cmp.
module pse_core #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pse_pkg::item_t item,
  input  pse_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output pse_pkg::res_t  res
);
  import pse_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam logic [AW-1:0] LAST_MAX = AW'(MAX_LEN - 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN0 = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_Q0    = 4'd3;
  localparam logic [3:0] S_Q     = 4'd4;
  localparam logic [3:0] S_SW    = 4'd5;
  localparam logic [3:0] S_REV_A = 4'd6;
  localparam logic [3:0] S_REV_B = 4'd7;
  localparam logic [3:0] S_REV_C = 4'd8;
  localparam logic [3:0] S_REV_D = 4'd9;
  localparam logic [3:0] S_EM0   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0]            state_r, state_nxt;
  logic [AW-1:0]         dp_r, dp_nxt;
  logic [AW-1:0]         p_r, p_nxt;
  logic [AW-1:0]         lo_r, lo_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [ELEM_WIDTH-1:0] hold_r, hold_nxt;
  logic [ELEM_WIDTH-1:0] pv_r, pv_nxt;
  logic                  dir_r, dir_nxt;
  logic                  adv_r, adv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  res_r, res_nxt;

  logic [ELEM_WIDTH-1:0] mem [MAX_LEN];
  logic [ELEM_WIDTH-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [ELEM_WIDTH-1:0] mem_wd;

  logic [AW-1:0]         used_last;
  logic [AW-1:0]         dp_dec;
  logic [ELEM_WIDTH-1:0] cmp_a, cmp_b;
  logic                  cmp_ahead;
  logic                  out_free;

  // Clamp the configured length and turn it into the last index in use
  always_comb begin
    if (cfg.seq_length == '0) begin
      used_last = '0;
    end else if (32'(cfg.seq_length) > MAX_LEN) begin
      used_last = LAST_MAX;
    end else begin
      used_last = AW'(cfg.seq_length - SEQ_LEN_W'(1));
    end
  end

  assign dp_dec   = (dp_r == '0) ? '0 : dp_r - AW'(1);
  assign out_free = !out_valid_r || out_ready;

  // Route the shared compare: pivot scan, then successor search
  assign cmp_a = (state_r == S_Q) ? pv_r : rd_data_r;
  assign cmp_b = (state_r == S_Q) ? rd_data_r : hold_r;

  pse_cmp #(.W(ELEM_WIDTH)) u_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .prev  (dir_r),
    .ahead (cmp_ahead)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    dp_nxt        = dp_r;
    p_nxt         = p_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    hold_nxt      = hold_r;
    pv_nxt        = pv_r;
    dir_nxt       = dir_r;
    adv_nxt       = adv_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_wa        = dp_r;
    mem_wd        = pv_r;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = used_last;
          dir_nxt  = cfg.direction;
          adv_nxt  = 1'b0;
          unique case (item.cmd)
            CMD_WRITE: begin
              if (32'(item.position) < MAX_LEN) begin
                mem_we = 1'b1;
                mem_wa = AW'(item.position);
                mem_wd = ELEM_WIDTH'(item.value);
              end
            end
            CMD_STEP: begin
              state_nxt = (used_last == '0) ? S_EM0 : S_SCAN0;
            end
            CMD_READ: begin
              state_nxt = S_EM0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Issue the rightmost element
      S_SCAN0: begin
        rd_addr   = last_r;
        dp_nxt    = last_r;
        state_nxt = S_SCAN;
      end

      // Walk left one element a cycle looking for the pivot
      S_SCAN: begin
        rd_addr = dp_dec;
        if (dp_r == last_r) begin
          hold_nxt = rd_data_r;
          dp_nxt   = dp_dec;
        end else if (cmp_ahead) begin
          p_nxt     = dp_r;
          pv_nxt    = rd_data_r;
          state_nxt = S_Q0;
        end else if (dp_r == '0) begin
          lo_nxt    = '0;
          hi_nxt    = last_r;
          state_nxt = S_REV_A;
        end else begin
          hold_nxt = rd_data_r;
          dp_nxt   = dp_dec;
        end
      end

      S_Q0: begin
        rd_addr   = last_r;
        dp_nxt    = last_r;
        state_nxt = S_Q;
      end

      // Find the rightmost element that follows the pivot; write it at the pivot
      S_Q: begin
        if (cmp_ahead) begin
          mem_we    = 1'b1;
          mem_wa    = p_r;
          mem_wd    = rd_data_r;
          state_nxt = S_SW;
        end else begin
          rd_addr = dp_dec;
          dp_nxt  = dp_dec;
        end
      end

      // Complete the swap and reverse the suffix
      S_SW: begin
        mem_we    = 1'b1;
        mem_wa    = dp_r;
        mem_wd    = pv_r;
        adv_nxt   = 1'b1;
        lo_nxt    = p_r + AW'(1);
        hi_nxt    = last_r;
        state_nxt = S_REV_A;
      end

      S_REV_A: begin
        rd_addr = lo_r;
        if (lo_r < hi_r) begin
          state_nxt = S_REV_B;
        end else begin
          state_nxt = S_EM0;
        end
      end

      S_REV_B: begin
        rd_addr   = hi_r;
        hold_nxt  = rd_data_r;
        state_nxt = S_REV_C;
      end

      S_REV_C: begin
        mem_we    = 1'b1;
        mem_wa    = lo_r;
        mem_wd    = rd_data_r;
        state_nxt = S_REV_D;
      end

      S_REV_D: begin
        mem_we    = 1'b1;
        mem_wa    = hi_r;
        mem_wd    = hold_r;
        lo_nxt    = lo_r + AW'(1);
        hi_nxt    = hi_r - AW'(1);
        state_nxt = S_REV_A;
      end

      S_EM0: begin
        rd_addr   = '0;
        k_nxt     = '0;
        state_nxt = S_EMIT;
      end

      // Stream one element a cycle into the result register; hold on stall
      S_EMIT: begin
        rd_addr = k_r;
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          res_nxt.position = POS_W'(k_r);
          res_nxt.value    = VAL_W'(rd_data_r);
          res_nxt.last     = (k_r == last_r);
          res_nxt.advanced = adv_r;
          if (k_r == last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt   = k_r + AW'(1);
            rd_addr = k_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Element memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dp_r   <= dp_nxt;
    p_r    <= p_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    k_r    <= k_nxt;
    last_r <= last_nxt;
    hold_r <= hold_nxt;
    pv_r   <= pv_nxt;
    dir_r  <= dir_nxt;
    adv_r  <= adv_nxt;
    res_r  <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

### hw/rtl/permutation_step_engine_unit.sv
// A write request leaves the block ready; a read emits n results through S_EM0 and S_EMIT.
// A step scans for the pivot, searches for its successor, swaps them and reverses the suffix
// pair by pair (REV_A to REV_D) in one memory with one write and one read port, then emits.
// Throughput: one request at a time; results stream at one per cycle without back pressure.
// Reset: rst_n synchronous active low clears sequencer and result valid; direction 0, length 16.
// Element storage is not cleared by reset.
module permutation_step_engine_unit #(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cmd [1:0], position [5:2], value [21:6], zero [23:22]
  input  logic [23:0]                        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_position [3:0], out_value [19:4], zero [23:20]
  output logic [23:0]                        out_tdata,
  output logic                               out_tlast,
  // advanced [0]
  output logic [0:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pse_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pse_pkg::*;

  logic                 direction_r;
  logic [SEQ_LEN_W-1:0] seq_length_r;
  item_t                item;
  cfg_t                 cfg;
  res_t                 res;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= 1'b0;
      seq_length_r <= SEQ_LENGTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIRECTION:  direction_r  <= cfg_data[0];
        REG_SEQ_LENGTH: seq_length_r <= cfg_data[SEQ_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.direction  = direction_r;
  assign cfg.seq_length = seq_length_r;

  // Unpack the request
  assign item.cmd      = in_tdata[1:0];
  assign item.position = in_tdata[5:2];
  assign item.value    = in_tdata[21:6];

  pse_core #(
    .MAX_LEN    (MAX_LEN),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .cfg       (cfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // Pack the result
  assign out_tdata = {4'b0, res.value, res.position};
  assign out_tlast = res.last;
  assign out_tuser = res.advanced;

`ifndef SYNTHESIS
  // A write or an unused command leaves the block ready for the next request
  a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[1:0] == CMD_WRITE || in_tdata[1:0] == CMD_NONE))
    |=> in_tready)
    else $error("ready dropped after a write request");

  // A step or read starts a run and blocks further requests
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tdata[1:0] == CMD_STEP || in_tdata[1:0] == CMD_READ))
    |=> !in_tready)
    else $error("ready still high after a step or read request");

  // Once idle, only the final result of a run can still be pending
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && in_tready) |-> out_tlast)
    else $error("idle while a run is still being emitted");
`endif

endmodule

### dv/pse_checker.sv
`timescale 1ns / 1ps
// Stream checker for the permutation step engine: tracks requests and register writes,
// predicts each emitted element and compares it with the result stream.
// Depends on pse_pkg for codes, register indexes and the result struct.
module pse_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [23:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,
  input  logic                           out_tlast,
  input  logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             checked
);
  import pse_pkg::*;

  localparam int MAX_LEN = 16;

  // Shadow copy of the sequence and the register settings
  logic [VAL_W-1:0]     seq_mem [MAX_LEN];
  logic                 walk_down;
  logic [SEQ_LEN_W-1:0] len_reg;
  res_t                 owed_elems [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] checker: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Clamp the length register to the range the block actually uses
  function automatic int active_len();
    if (len_reg == '0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return int'(len_reg);
  endfunction

  function automatic bit precedes(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                                  input bit rev);
    return rev ? (a > b) : (a < b);
  endfunction

  function automatic void swap_elems(input int a, input int b);
    logic [VAL_W-1:0] t;
    t = seq_mem[a];
    seq_mem[a] = seq_mem[b];
    seq_mem[b] = t;
  endfunction

  function automatic void reverse_elems(input int lo, input int hi);
    while (lo < hi) begin
      swap_elems(lo, hi);
      lo++;
      hi--;
    end
  endfunction

  // Rearrange into the lexicographic successor (or predecessor); wrap when none exists
  function automatic bit permute_in_place(input int n, input bit rev);
    int q;
    if (n < 2) return 1'b0;
    for (int p = n - 2; p >= 0; p--) begin
      if (precedes(seq_mem[p], seq_mem[p + 1], rev)) begin
        q = n - 1;
        while (!precedes(seq_mem[p], seq_mem[q], rev)) q--;
        swap_elems(p, q);
        reverse_elems(p + 1, n - 1);
        return 1'b1;
      end
    end
    reverse_elems(0, n - 1);
    return 1'b0;
  endfunction

  // Apply one accepted request and queue the elements it emits
  task automatic accept_request(input logic [23:0] d);
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;
    logic [VAL_W-1:0] v;
    logic             adv;
    int               n;
    res_t             r;
    c = d[1:0];
    p = d[5:2];
    v = d[21:6];
    case (c) inside
      CMD_WRITE: seq_mem[p] = v;
      CMD_STEP, CMD_READ: begin
        n   = active_len();
        adv = 1'b0;
        if (c == CMD_STEP) adv = permute_in_place(n, walk_down);
        for (int k = 0; k < n; k++) begin
          r.position = POS_W'(k);
          r.value    = seq_mem[k];
          r.last     = (k == n - 1);
          r.advanced = adv;
          owed_elems.insert(owed_elems.size(), r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    res_t w;
    if (!rst_n) begin
      walk_down = 1'b0;
      len_reg   = SEQ_LENGTH_RST;
      owed_elems.delete();
    end else begin
      // The user must make register writes only while the block is idle; the block does not enforce it
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIRECTION:  walk_down = cfg_data[0];
          REG_SEQ_LENGTH: len_reg   = cfg_data;
          default: ;
        endcase
      end
      // Compare the result against the oldest owed element
      if (out_tvalid && out_tready) begin
        checked++;
        if (owed_elems.size() == 0) begin
          report_mismatch("result with nothing owed, data", 32'(out_tdata), '0);
        end else begin
          w = owed_elems.pop_front();
          if (out_tdata[3:0] != w.position)
            report_mismatch("out_position", 32'(out_tdata[3:0]), 32'(w.position));
          if (out_tdata[19:4] != w.value)
            report_mismatch($sformatf("out_value at %0d", w.position),
                            32'(out_tdata[19:4]), 32'(w.value));
          if (out_tlast != w.last)
            report_mismatch($sformatf("tlast at %0d", w.position),
                            32'(out_tlast), 32'(w.last));
          if (out_tuser[0] != w.advanced)
            report_mismatch($sformatf("advanced at %0d", w.position),
                            32'(out_tuser[0]), 32'(w.advanced));
          if (out_tdata[23:20] != '0)
            report_mismatch("tdata pad bits", 32'(out_tdata[23:20]), '0);
        end
      end
      if (in_tvalid && in_tready) accept_request(in_tdata);
    end
    pending = owed_elems.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for permutation_step_engine_unit: drives requests and register writes
// under several pacing phases and gives the verdict. Depends on pse_pkg and pse_checker.
module tb;
  import pse_pkg::*;

  localparam int MAX_LEN   = 16;
  localparam int DRAIN     = 8;
  localparam int BURST     = 40;
  localparam int LIMIT_NS  = 18_000_000;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic [0:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int checked;

  int          src_idle;
  int          snk_stall;
  int          live_len;
  logic [15:0] loaded;
  int          n_write;
  int          n_step;
  int          n_read;
  int          n_skip;

  permutation_step_engine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pse_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always #6 clk = ~clk;

  // Stall the result side at the current phase rate
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_stall);
  end

  // Hard stop if the run hangs
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // Present one request after an optional idle gap; hold it until accepted
  task automatic issue(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                       input logic [VAL_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, v, p, c};
    do @(posedge clk); while (!in_tready);
    case (c)
      CMD_WRITE: begin
        loaded[p] = 1'b1;
        n_write++;
      end
      CMD_STEP: n_step++;
      CMD_READ: n_read++;
      default:  n_skip++;
    endcase
  endtask

  // Step or read, unless an element in use was never written: then write the lowest such element instead
  task automatic emit(input logic [CMD_W-1:0] c);
    int gap = -1;
    for (int i = live_len - 1; i >= 0; i--) if (!loaded[i]) gap = i;
    if (gap >= 0) issue(CMD_WRITE, POS_W'(gap), VAL_W'($urandom_range(65535)));
    else issue(c, POS_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_length(input logic [CFG_DATA_W-1:0] d);
    cfg_write(REG_SEQ_LENGTH, d);
    live_len = (d == '0) ? 1 : ((d > MAX_LEN) ? MAX_LEN : int'(d));
  endtask

  // Drop the request valid, wait for every owed result, then let the core go quiet
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  initial begin
    int r;
    int k;
    int base;
    logic [CFG_DATA_W-1:0] lv;

    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    src_idle   = 0;
    snk_stall  = 0;
    live_len   = MAX_LEN;
    loaded     = '0;
    n_write    = 0;
    n_step     = 0;
    n_read     = 0;
    n_skip     = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: descending start wraps on a forward step, then advances
    set_length(5'd4);
    cfg_write(REG_DIRECTION, 5'd0);
    cfg_write(REG_SPARE, 5'd31);
    issue(CMD_WRITE, 4'd0, 16'hFFFF);
    issue(CMD_WRITE, 4'd1, 16'hAAAA);
    issue(CMD_WRITE, 4'd2, 16'h5555);
    issue(CMD_WRITE, 4'd3, 16'h0000);
    issue(CMD_STEP, 4'hF, 16'hFFFF);
    issue(CMD_STEP, 4'h0, 16'h0000);
    issue(CMD_READ, 4'hA, 16'h1234);
    issue(CMD_NONE, 4'h5, 16'hBEEF);
    // Beyond the length in use but still stored
    issue(CMD_WRITE, 4'd15, 16'h8001);
    settle();

    // Backward steps over repeated values, with a wrap to the last order on the second step
    cfg_write(REG_DIRECTION, 5'd1);
    issue(CMD_WRITE, 4'd1, 16'h0000);
    issue(CMD_STEP, 4'd3, 16'h00FF);
    issue(CMD_STEP, 4'd0, 16'h0000);
    issue(CMD_STEP, 4'd0, 16'h0000);
    settle();

    // Single element and a zero length register both leave the sequence alone
    set_length(5'd1);
    issue(CMD_STEP, 4'd0, 16'h0000);
    issue(CMD_READ, 4'd0, 16'h0000);
    settle();
    set_length(5'd0);
    issue(CMD_STEP, 4'd0, 16'h0000);

    // Random bursts under four pacing phases, three settings each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 83; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 83; end
        default: begin src_idle = 17; snk_stall = 17; end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        k = ph * 3 + sub;
        settle();
        r = $urandom_range(99);
        case (k)
          0: lv = 5'd16;
          1: lv = 5'd1;
          5: lv = 5'd0;
          8: lv = 5'd31;
          default: begin
            if (r < 60)      lv = CFG_DATA_W'($urandom_range(5, 2));
            else if (r < 80) lv = CFG_DATA_W'($urandom_range(16, 6));
            else if (r < 88) lv = 5'd1;
            else             lv = CFG_DATA_W'($urandom_range(31, 17));
          end
        endcase
        set_length(lv);
        cfg_write(REG_DIRECTION, CFG_DATA_W'($urandom_range(31)));
        base = n_write + n_step + n_read;
        while (n_write + n_step + n_read - base < BURST) begin
          r = $urandom_range(99);
          if (r < 3) begin
            issue(CMD_NONE, POS_W'($urandom), VAL_W'($urandom));
          end else if (r < 25) begin
            // Mostly inside the length in use; small values to force repeats
            issue(CMD_WRITE,
                  ($urandom_range(3) == 0) ? POS_W'($urandom_range(15))
                                           : POS_W'($urandom_range(live_len - 1)),
                  $urandom_range(1) ? VAL_W'($urandom_range(3))
                                    : VAL_W'($urandom_range(65535)));
          end else if (r < 38) begin
            emit(CMD_READ);
          end else begin
            emit(CMD_STEP);
          end
        end
      end
    end

    settle();
    repeat (20) @(negedge clk);
    $display("Covered %0d writes, %0d steps, %0d reads and %0d unused commands",
             n_write, n_step, n_read, n_skip);
    $display("%0d emitted elements compared over four pacing phases and lengths 0 to 31",
             checked);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
